// ===== design/vrap_pkg.sv =====
package vrap_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WORD  = 2'd1;
    localparam logic [1:0] ACT_BYTE  = 2'd2;

    // register byte offsets in the port window
    localparam logic [3:0] OFF_PTR    = 4'd0;
    localparam logic [3:0] OFF_DATA   = 4'd2;
    localparam logic [3:0] OFF_STEP   = 4'd4;
    localparam logic [3:0] OFF_SPEED  = 4'd6;
    localparam logic [3:0] OFF_DATA_B = 4'd8;
    localparam logic [3:0] OFF_DATA_C = 4'd10;

    localparam logic [7:0] SPEED_FLAG = 8'h80;

    localparam int unsigned RAM_WORDS_DEF = 65536;

    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned WORD_W     = 16;

endpackage

// ===== design/video_ram_autoincrement_port.sv =====
// channel  | dir | beat contents (tdata / tuser, low bit first)
// s_axis   | in  | tdata: reg_offset[3:0], write_data[19:4], frame_phase[22:20], zero[23]
//          |     | tuser: action[1:0]
// m_axis   | out | tdata: read_data[15:0]
//
// An item runs in two steps: the RAM read at the pointer index on acceptance, then the
// read-modify-write and result in the next cycle. Writes that move the pointer then
// rebuild the RAM index (pointer mod RAM_WORDS) through a reciprocal multiply
// (ST_IDX_Q) and a multiply-subtract (ST_IDX_R) before the next beat is taken.
// Synchronous active-low reset clears pointer, step, speed byte and control; the
// RAM is not cleared. The result sits in an output register, so the next beat is
// taken while it waits unless m_axis_tready is holding it.
module video_ram_autoincrement_port
    import vrap_pkg::*;
#(
    parameter int unsigned RAM_WORDS = RAM_WORDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // reg_offset, write_data, frame_phase
    input  logic [1:0]            s_axis_tuser,  // action

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // read_data
);

    localparam int unsigned AW      = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
    localparam longint unsigned RECIP_L =
        ((64'd1 << 32) + longint'(RAM_WORDS) - 64'd1) / longint'(RAM_WORDS);
    localparam int unsigned RW      = 25;
    localparam int unsigned PW      = WORD_W + RW;
    localparam int unsigned QW      = PW - 32;
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
    localparam logic [WORD_W:0] DEPTH = (WORD_W+1)'(RAM_WORDS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_IDX_Q = 2'd2;
    localparam logic [1:0] ST_IDX_R = 2'd3;

    logic [15:0] mem [RAM_WORDS];

    logic [1:0]        r_state, n_state;
    logic [WORD_W-1:0] r_ptr, n_ptr;
    logic [WORD_W-1:0] r_step, n_step;
    logic [7:0]        r_speed, n_speed;
    logic [AW-1:0]     r_idx;
    logic [QW-1:0]     r_quot;
    logic [WORD_W-1:0] r_rd;

    logic [1:0]        r_act;
    logic [3:0]        r_off;
    logic [WORD_W-1:0] r_wdata;
    logic [2:0]        r_phase;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic              s_fire;
    logic              do_write;
    logic              mem_we;
    logic [WORD_W-1:0] reg_val;
    logic [WORD_W-1:0] wr_val;
    logic [PW-1:0]     quot_prod;
    logic [WORD_W:0]   rem;

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // register read value, also the base of a byte-write merge
    always_comb begin
        case (r_off)
            OFF_PTR, OFF_DATA, OFF_DATA_B, OFF_DATA_C: reg_val = r_rd;
            OFF_STEP:  reg_val = r_step;
            OFF_SPEED: reg_val = {r_speed, SPEED_FLAG | {5'd0, r_phase}};
            default:   reg_val = '0;
        endcase
    end

    assign do_write = (r_act == ACT_WORD) || ((r_act == ACT_BYTE) && !r_off[0]);
    assign wr_val   = (r_act == ACT_WORD) ? r_wdata : {reg_val[15:8], r_wdata[7:0]};
    assign mem_we   = (r_state == ST_EXEC) && do_write && (r_off == OFF_DATA);

    assign quot_prod = PW'(r_ptr) * PW'(RECIP);
    assign rem       = (WORD_W+1)'(r_ptr) - (WORD_W+1)'(r_quot) * DEPTH;

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_step  = r_step;
        n_speed = r_speed;
        case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                if (do_write) begin
                    case (r_off)
                        OFF_PTR: begin
                            n_ptr   = wr_val;
                            n_state = ST_IDX_Q;
                        end
                        OFF_DATA: begin
                            n_ptr   = r_ptr + r_step;
                            n_state = ST_IDX_Q;
                        end
                        OFF_STEP:  n_step  = wr_val;
                        OFF_SPEED: n_speed = wr_val[15:8];
                        default: ;
                    endcase
                end
            end
            ST_IDX_Q: n_state = ST_IDX_R;
            ST_IDX_R: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_step      <= '0;
            r_speed     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_step  <= n_step;
            r_speed <= n_speed;
            if (r_state == ST_IDX_R) begin
                r_idx <= rem[AW-1:0];
            end
            if (r_state == ST_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_act   <= s_axis_tuser;
            r_off   <= s_axis_tdata[3:0];
            r_wdata <= s_axis_tdata[19:4];
            r_phase <= s_axis_tdata[22:20];
        end
        if (r_state == ST_IDX_Q) begin
            r_quot <= quot_prod[PW-1:32];
        end
        if (r_state == ST_EXEC) begin
            r_out_data <= (r_act == ACT_READ) ? reg_val : '0;
        end
    end

    // index only changes outside IDLE, so the read on acceptance never meets a write
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx] <= wr_val;
        end
        if (s_fire) begin
            r_rd <= mem[r_idx];
        end
    end

    a_exec_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EXEC |=> r_out_valid)
        else $error("result not loaded after execute");

    a_write_returns_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) && (r_act != ACT_READ) |=> r_out_data == '0)
        else $error("write returned nonzero data");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDX_R |=> (WORD_W+1)'(r_idx) < DEPTH)
        else $error("RAM index out of range");

    a_ptr_only_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_EXEC |=> $stable(r_ptr) && $stable(r_step) && $stable(r_speed))
        else $error("port state changed outside execute");

    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("beat accepted while result stalled");

endmodule
